// ===== rtl/laq_pkg.sv =====
// ----------------------------------------------------------------------------
// laq_pkg
// shared constants, codes and types for the linear array queue unit
// ----------------------------------------------------------------------------
package laq_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STS_W  = 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ  = 3'd0;
  localparam logic [OP_W-1:0] OP_DEQ  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
  localparam logic [OP_W-1:0] OP_SHOW = 3'd3;
  localparam logic [OP_W-1:0] OP_STAT = 3'd4;

  // status codes
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

  // request to the slot memory
  typedef struct packed {
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
  } ram_req_t;

endpackage

// ===== rtl/linear_array_queue_unit.sv =====
// ----------------------------------------------------------------------------
// linear_array_queue_unit
// Non-circular array queue of DEPTH signed words held in a synchronous slot
// memory. Each input transfer carries one operation (enqueue, dequeue, peek,
// display, status) and causes one or more output transfers, the final one
// marked by last; every result carries the empty and full flags as they stand
// after the operation. The queue reports full once the rear index reaches the
// last slot, even when dequeues have freed slots at the front, and dequeuing
// the final word resets both indices to zero. Timing: enqueue, status and any
// rejected operation finish in the cycle of the input transfer, so they can
// follow one another every cycle while the output side keeps up. Dequeue and
// peek pass through the read state because the head word comes out of the
// memory in the cycle after the read is issued. Display walks the memory
// read port one slot per cycle over the stored words, from front to rear.
// A result waiting in the output register stalls that walk and holds off new
// input transfers; the slot memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module linear_array_queue_unit (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [laq_pkg::OP_W-1:0]          operation,
  input  logic signed [laq_pkg::DATA_W-1:0] value,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [laq_pkg::STS_W-1:0]         status,
  output logic signed [laq_pkg::DATA_W-1:0] data,
  output logic                              data_valid,
  output logic                              is_empty,
  output logic                              is_full,
  output logic                              last
);
  import laq_pkg::*;

  // sequencer states
  localparam logic S_IDLE = 1'b0;  // ready for an input transfer
  localparam logic S_READ = 1'b1;  // memory read in flight or waiting to drain

  logic             state, state_next;
  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             empty, empty_next;
  logic             walk, walk_next;      // display walk in progress
  logic [IDX_W-1:0] rd_idx, rd_idx_next;  // slot whose word is in rd_data

  ram_req_t                 ram_req;
  logic signed [DATA_W-1:0] rd_data;

  logic                     out_free;
  logic                     accept;
  logic                     full;
  logic                     load;
  logic [STS_W-1:0]         res_status;
  logic signed [DATA_W-1:0] res_data;
  logic                     res_dv;
  logic                     res_last;

  laq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = !empty && (tail == LAST_IDX);

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    walk_next   = walk;
    rd_idx_next = rd_idx;
    ram_req     = '0;
    load        = 1'b0;
    res_status  = STS_OK;
    res_data    = '0;
    res_dv      = 1'b0;
    res_last    = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (operation)
            OP_ENQ: begin
              load = 1'b1;
              if (full) begin
                res_status = STS_FULL;
              end else begin
                if (empty) begin
                  // first word always lands in slot zero
                  head_next = '0;
                  tail_next = '0;
                end else begin
                  tail_next = tail + 1'b1;
                end
                empty_next      = 1'b0;
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = tail_next;
                ram_req.wr_data = value;
                res_data        = value;
                res_dv          = 1'b1;
              end
            end
            OP_DEQ, OP_PEEK, OP_SHOW: begin
              if (empty) begin
                load       = 1'b1;
                res_status = STS_EMPTY;
              end else begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = head;
                rd_idx_next     = head;
                walk_next       = (operation == OP_SHOW);
                state_next      = S_READ;
                if (operation == OP_DEQ) begin
                  if (head == tail) begin
                    // last word leaves: restart at slot zero
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                  end else begin
                    head_next = head + 1'b1;
                  end
                end
              end
            end
            default: begin
              // status query, unused codes act the same
              load = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load     = 1'b1;
          res_data = rd_data;
          res_dv   = 1'b1;
          res_last = !walk || (rd_idx == tail);
          if (res_last) begin
            state_next = S_IDLE;
            walk_next  = 1'b0;
          end else begin
            // fetch the next slot of the display walk
            rd_idx_next     = rd_idx + 1'b1;
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = rd_idx_next;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      empty     <= 1'b1;
      walk      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      empty     <= empty_next;
      walk      <= walk_next;
      out_valid <= load || (out_valid && out_stall);
    end
  end

  // payload registers, flags taken after the operation
  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    if (load) begin
      status     <= res_status;
      data       <= res_data;
      data_valid <= res_dv;
      is_empty   <= empty_next;
      is_full    <= !empty_next && (tail_next == LAST_IDX);
      last       <= res_last;
    end
  end

endmodule

// ===== rtl/laq_ram.sv =====
// ----------------------------------------------------------------------------
// laq_ram
// slot memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module laq_ram (
  input  logic                              clk,
  input  laq_pkg::ram_req_t                 req,
  output logic signed [laq_pkg::DATA_W-1:0] rd_data
);
  import laq_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== rtl/laq_checker.sv =====
// ----------------------------------------------------------------------------
// laq_checker
// port-level checks on the input and result streams of the queue unit
// ----------------------------------------------------------------------------
module laq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [laq_pkg::OP_W-1:0]          operation,
  input logic signed [laq_pkg::DATA_W-1:0] value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [laq_pkg::STS_W-1:0]         status,
  input logic signed [laq_pkg::DATA_W-1:0] data,
  input logic                              data_valid,
  input logic                              is_empty,
  input logic                              is_full,
  input logic                              last
);
  import laq_pkg::*;

  // full and empty never show together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_full && is_empty))
    else $error("full and empty flags both set");

  // a rejected operation gives one bare result
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STS_OK) |-> !data_valid && last && (data == '0))
    else $error("rejected result carries data or is not last");

  // rejection codes agree with the flags
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == STS_FULL && !is_full) || (status == STS_EMPTY && !is_empty))
    |-> 1'b0)
    else $error("rejection code disagrees with flags");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(data) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // a stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(operation) && $stable(value))
    else $error("stalled input payload changed");

endmodule

bind linear_array_queue_unit laq_checker u_laq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .operation  (operation),
  .value      (value),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .data       (data),
  .data_valid (data_valid),
  .is_empty   (is_empty),
  .is_full    (is_full),
  .last       (last)
);
